@@ hdl/dcap_pkg.sv @@
// shared definitions for the delta context address predictor
// operation codes, field widths, hash and confidence constants, parameter defaults
// no dependencies
package dcap_pkg;

	typedef enum logic {
		FUNC_UPDATE    = 1'b0,
		FUNC_LOOKAHEAD = 1'b1
	} func_t;

	localparam int HISTORY_ENTRIES_DEF = 256;
	localparam int DELTA_ENTRIES_DEF   = 512;
	localparam int ADDR_BITS_DEF       = 32;

	localparam int TAG_W       = 16;
	localparam int LAST_W      = 16;
	localparam int DELTA_W     = 16;
	localparam int CONF_W      = 2;
	localparam int HIST_PORT_W = 9;
	localparam int HASH_SHIFT  = 5;

	localparam logic [CONF_W-1:0] CONF_ZERO    = 2'd0;
	localparam logic [CONF_W-1:0] CONF_MAX     = 2'd3;
	localparam logic [CONF_W-1:0] CONF_PREDICT = 2'd2;

endpackage

@@ hdl/delta_context_address_predictor.sv @@
// delta context address predictor: history table, delta table, prediction datapath
// depends on dcap_pkg and dcap_ram
//
// pipeline: history read, delta read, result register
// throughput: one item per cycle; stalls while the result register is held by m_axis_tready
// and while the reset clearing pass runs
// reset: arst_n clears control state, then a clearing pass over the deeper of the two tables
// zeroes both tables, with s_axis_tready low throughout
// table read-after-write hazards between back-to-back items are resolved by forwarding
module delta_context_address_predictor #(
	parameter int HISTORY_ENTRIES = dcap_pkg::HISTORY_ENTRIES_DEF,
	parameter int DELTA_ENTRIES   = dcap_pkg::DELTA_ENTRIES_DEF,
	parameter int ADDR_BITS       = dcap_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // pc[31:0], addr[63:32], history_in[72:64], prev_addr_in[88:73]
	input  logic [0:0]  s_axis_tuser,  // func[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // predicted_addr[31:0], hist_out[40:32]
	output logic [0:0]  m_axis_tuser   // predict_valid[0]
);

	import dcap_pkg::*;

	localparam int HBITS  = $clog2(HISTORY_ENTRIES + 1) - 1;
	localparam int DBITS  = $clog2(DELTA_ENTRIES + 1) - 1;
	localparam int HDEPTH = 1 << HBITS;
	localparam int DDEPTH = 1 << DBITS;
	localparam int CBITS  = (HBITS > DBITS) ? HBITS : DBITS;
	localparam int AW     = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int HW     = (DBITS > HIST_PORT_W) ? DBITS : HIST_PORT_W;
	localparam int EW     = TAG_W + LAST_W + DBITS + CONF_W;

	function automatic logic [DBITS-1:0] hash_hist(logic [DBITS-1:0] old_h,
		logic [DELTA_W-1:0] d);
		logic [DBITS-1:0] f;
		f = '0;
		for (int i = 0; i < DELTA_W; i++) begin
			f[i % DBITS] = f[i % DBITS] ^ d[i];
		end
		return (old_h << HASH_SHIFT) ^ f;
	endfunction

	// control
	logic             en1, en2, en3;
	logic             v1_s1, v2_s2, out_valid_q;
	logic             clr_busy_q;
	logic [CBITS-1:0] clr_cnt_q;

	// stage 1 payload
	func_t             func_s1;
	logic [HBITS-1:0]  idx_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [31:0]       addr_s1;
	logic [DBITS-1:0]  hin_s1;
	logic [LAST_W-1:0] last_in_s1;

	// stage 2 payload
	func_t              func_s2;
	logic [HBITS-1:0]   idx_s2;
	logic [TAG_W-1:0]   tag_s2;
	logic [31:0]        addr_s2;
	logic [DELTA_W-1:0] act_s2;
	logic [DBITS-1:0]   oh_s2, nh_s2;
	logic               hit_s2;
	logic [CONF_W-1:0]  conf_s2;

	// result register
	logic [31:0]            pred_q;
	logic                   pv_q;
	logic [HIST_PORT_W-1:0] nh_q;

	// last table writes, for forwarding
	logic               wr_v_q, dwr_v_q;
	logic [HBITS-1:0]   wr_idx_q;
	logic [EW-1:0]      wr_data_q;
	logic [DBITS-1:0]   dwr_idx_q;
	logic [DELTA_W-1:0] dwr_data_q;

	// ram ports
	logic               hwe, dwe;
	logic [HBITS-1:0]   hwaddr;
	logic [EW-1:0]      hwdata, hrd;
	logic [DBITS-1:0]   dwaddr;
	logic [DELTA_W-1:0] dwdata, rd_a, rd_b;

	// stage 1 logic
	logic [EW-1:0]      ent;
	logic [TAG_W-1:0]   e_tag;
	logic [LAST_W-1:0]  e_last;
	logic [DBITS-1:0]   e_hist;
	logic [CONF_W-1:0]  e_conf;
	logic               hit1;
	logic [DELTA_W-1:0] act1;
	logic [DBITS-1:0]   nh1;
	logic [HW-1:0]      hin_wide;

	// stage 2 logic
	logic [DELTA_W-1:0] d_a, d_b;
	logic [CONF_W-1:0]  conf_n;
	logic [AW-1:0]      sum;
	logic [EW-1:0]      item_hdata;
	logic               item_hwe, item_dwe;
	logic [31:0]        pred_n;
	logic               pv_n;
	logic [HIST_PORT_W-1:0] nh_n;
	logic [HW-1:0]      nh_wide;

	assign en3 = !out_valid_q || m_axis_tready;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign s_axis_tready = en1 && !clr_busy_q;

	// ---------------- tables ----------------

	dcap_ram #(.WIDTH(EW), .DEPTH(HDEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (hwe),
		.waddr (hwaddr),
		.wdata (hwdata),
		.re    (en1),
		.raddr (s_axis_tdata[HBITS-1:0]),
		.rdata (hrd)
	);

	// two copies of the delta table give two read ports
	dcap_ram #(.WIDTH(DELTA_W), .DEPTH(DDEPTH)) u_delta_ram_a (
		.clk   (clk),
		.we    (dwe),
		.waddr (dwaddr),
		.wdata (dwdata),
		.re    (en2),
		.raddr (e_hist),
		.rdata (rd_a)
	);

	dcap_ram #(.WIDTH(DELTA_W), .DEPTH(DDEPTH)) u_delta_ram_b (
		.clk   (clk),
		.we    (dwe),
		.waddr (dwaddr),
		.wdata (dwdata),
		.re    (en2),
		.raddr (nh1),
		.rdata (rd_b)
	);

	always_comb begin
		if (clr_busy_q) begin
			hwe    = (clr_cnt_q >> HBITS) == '0;
			hwaddr = clr_cnt_q[HBITS-1:0];
			hwdata = '0;
			dwe    = (clr_cnt_q >> DBITS) == '0;
			dwaddr = clr_cnt_q[DBITS-1:0];
			dwdata = '0;
		end else begin
			hwe    = item_hwe;
			hwaddr = idx_s2;
			hwdata = item_hdata;
			dwe    = item_dwe;
			dwaddr = oh_s2;
			dwdata = act_s2;
		end
	end

	// ---------------- stage 1 ----------------

	always_comb begin
		// newest older writer first: the item in stage 2, then the last write
		priority if (v2_s2 && func_s2 == FUNC_UPDATE && idx_s2 == idx_s1) begin
			ent = item_hdata;
		end else if (wr_v_q && wr_idx_q == idx_s1) begin
			ent = wr_data_q;
		end else begin
			ent = hrd;
		end
		{e_tag, e_last, e_hist, e_conf} = ent;
		hit1 = e_tag == tag_s1;
		if (func_s1 == FUNC_LOOKAHEAD) begin
			act1 = addr_s1[DELTA_W-1:0] - last_in_s1;
			nh1  = hash_hist(hin_s1, act1);
		end else begin
			act1 = addr_s1[DELTA_W-1:0] - e_last;
			nh1  = hash_hist(e_hist, act1);
		end
	end

	assign hin_wide = HW'(s_axis_tdata[72:64]);

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1    <= func_t'(s_axis_tuser[0]);
			idx_s1     <= s_axis_tdata[HBITS-1:0];
			tag_s1     <= s_axis_tdata[HBITS+TAG_W-1:HBITS];
			addr_s1    <= s_axis_tdata[63:32];
			hin_s1     <= hin_wide[DBITS-1:0];
			last_in_s1 <= s_axis_tdata[88:73];
		end
		if (en2) begin
			func_s2 <= func_s1;
			idx_s2  <= idx_s1;
			tag_s2  <= tag_s1;
			addr_s2 <= addr_s1;
			act_s2  <= act1;
			oh_s2   <= e_hist;
			nh_s2   <= nh1;
			hit_s2  <= hit1;
			conf_s2 <= e_conf;
		end
		if (en3) begin
			pred_q <= pred_n;
			pv_q   <= pv_n;
			nh_q   <= nh_n;
		end
		if (item_hwe) begin
			wr_idx_q  <= idx_s2;
			wr_data_q <= item_hdata;
		end
		if (item_dwe) begin
			dwr_idx_q  <= oh_s2;
			dwr_data_q <= act_s2;
		end
	end

	// ---------------- stage 2 ----------------

	always_comb begin
		d_a = (dwr_v_q && dwr_idx_q == oh_s2) ? dwr_data_q : rd_a;
		// own write at the old history is seen by the prediction read
		priority if (func_s2 == FUNC_UPDATE && nh_s2 == oh_s2) begin
			d_b = act_s2;
		end else if (dwr_v_q && dwr_idx_q == nh_s2) begin
			d_b = dwr_data_q;
		end else begin
			d_b = rd_b;
		end

		if (act_s2 == d_a) begin
			conf_n = (conf_s2 == CONF_MAX) ? conf_s2 : conf_s2 + 1'b1;
		end else begin
			conf_n = (conf_s2 == CONF_ZERO) ? conf_s2 : conf_s2 - 1'b1;
		end

		sum     = addr_s2[AW-1:0] + {{(AW-DELTA_W){d_b[DELTA_W-1]}}, d_b};
		nh_wide = HW'(nh_s2);

		if (hit_s2) begin
			item_hdata = {tag_s2, addr_s2[LAST_W-1:0], nh_s2, conf_n};
		end else begin
			item_hdata = {tag_s2, addr_s2[LAST_W-1:0], {DBITS{1'b0}}, CONF_ZERO};
		end
		item_hwe = v2_s2 && en3 && func_s2 == FUNC_UPDATE;
		item_dwe = item_hwe && hit_s2;

		unique case (func_s2)
			FUNC_LOOKAHEAD: begin
				pv_n   = 1'b1;
				pred_n = 32'(sum);
				nh_n   = nh_wide[HIST_PORT_W-1:0];
			end
			FUNC_UPDATE: begin
				pv_n   = hit_s2 && conf_n >= CONF_PREDICT;
				pred_n = pv_n ? 32'(sum) : 32'd0;
				nh_n   = hit_s2 ? nh_wide[HIST_PORT_W-1:0] : '0;
			end
			default: begin
				pv_n   = 1'b0;
				pred_n = 32'd0;
				nh_n   = '0;
			end
		endcase
	end

	// ---------------- control ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			out_valid_q <= 1'b0;
			wr_v_q      <= 1'b0;
			dwr_v_q     <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_cnt_q   <= '0;
		end else begin
			if (en1) begin
				v1_s1 <= s_axis_tvalid && s_axis_tready;
			end
			if (en2) begin
				v2_s2 <= v1_s1;
			end
			if (en3) begin
				out_valid_q <= v2_s2;
			end
			if (item_hwe) begin
				wr_v_q <= 1'b1;
			end
			if (item_dwe) begin
				dwr_v_q <= 1'b1;
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(48-32-HIST_PORT_W){1'b0}}, nh_q, pred_q};
	assign m_axis_tuser  = pv_q;

	// ---------------- assertions ----------------

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v1_s1 && !v2_s2 && !out_valid_q)
		else $error("item in flight during table clearing");

	a_miss_result: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && en3 && func_s2 == FUNC_UPDATE && !hit_s2
		|=> out_valid_q && !pv_q && pred_q == 32'd0 && nh_q == '0)
		else $error("tag miss produced a prediction or history");

	a_lookahead_valid: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && en3 && func_s2 == FUNC_LOOKAHEAD |=> out_valid_q && pv_q)
		else $error("lookahead result without prediction");

	a_no_pred_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
		else $error("nonzero address without prediction");

endmodule

@@ hdl/dcap_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module dcap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
